// ===== rtl/vertex_matrix_transform_defines.svh =====
// Assertion macros used by the vertex transform top level.
// Standalone header; expects a clock named clk and a reset named rst in scope.
`ifndef VERTEX_MATRIX_TRANSFORM_DEFINES_SVH
`define VERTEX_MATRIX_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vmt_pkg.sv =====
// Shared types and constants for the vertex matrix transform.
// No dependencies; used by vmt_dot4 and vertex_matrix_transform.
`default_nettype none

package vmt_pkg;

  localparam int WORD_W    = 32;
  localparam int COEF_W    = 64;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_COEF  = 8;
  localparam int NUM_WORDS = 2 * NUM_COEF;
  localparam int NUM_COMP  = 4;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_STG   = 4;

  localparam logic [CFG_IDX_W-1:0] NUM_COEF_IDX = CFG_IDX_W'(NUM_COEF);

  // Identity matrix in Q16.16.
  localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } vmt_adv_t;

endpackage

`default_nettype wire

// ===== rtl/vmt_dot4.sv =====
// One output component: four-term signed dot product, shift and saturate.
// Depends on vmt_pkg; stage enables come from the top-level pipeline control.
`default_nettype none

module vmt_dot4 #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                  clk,
  input  wire vmt_pkg::vmt_adv_t               adv,
  input  wire logic signed [vmt_pkg::WORD_W-1:0] vtx  [vmt_pkg::NUM_COMP],
  input  wire logic signed [vmt_pkg::WORD_W-1:0] coef [vmt_pkg::NUM_COMP],
  output logic signed [vmt_pkg::WORD_W-1:0]      comp
);

  logic signed [vmt_pkg::PROD_W-1:0] prod [vmt_pkg::NUM_COMP];
  logic signed [vmt_pkg::PAIR_W-1:0] pair [2];
  logic signed [vmt_pkg::SUM_W-1:0]  total;
  logic signed [vmt_pkg::SUM_W-1:0]  shifted;
  logic [vmt_pkg::SUM_W-vmt_pkg::WORD_W:0] top_bits;
  logic signed [vmt_pkg::WORD_W-1:0] comp_next;

  // Stage 1: one multiplier per term.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int i = 0; i < vmt_pkg::NUM_COMP; i++) begin
        prod[i] <= vtx[i] * coef[i];
      end
    end
  end

  // Stage 2: pairwise sums.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pair[0] <= vmt_pkg::PAIR_W'(prod[0]) + vmt_pkg::PAIR_W'(prod[1]);
      pair[1] <= vmt_pkg::PAIR_W'(prod[2]) + vmt_pkg::PAIR_W'(prod[3]);
    end
  end

  // Stage 3: exact full-width sum.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      total <= vmt_pkg::SUM_W'(pair[0]) + vmt_pkg::SUM_W'(pair[1]);
    end
  end

  // Stage 4: floor shift, then clamp to the signed word range.
  always_comb begin
    shifted  = total >>> FRAC_BITS;
    top_bits = shifted[vmt_pkg::SUM_W-1:vmt_pkg::WORD_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      comp_next = shifted[vmt_pkg::WORD_W-1:0];
    end else if (shifted[vmt_pkg::SUM_W-1]) begin
      comp_next = vmt_pkg::SAT_MIN;
    end else begin
      comp_next = vmt_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      comp <= comp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vertex_matrix_transform.sv =====
// Top level of the vertex matrix transform: config registers, pipeline control, four columns.
// Depends on vmt_pkg, vmt_dot4 and vertex_matrix_transform_defines.svh.
`default_nettype none
`include "vertex_matrix_transform_defines.svh"

// Multiplies each homogeneous vertex (x, y, z, w in signed Q16.16) by a 4x4 matrix
// held in eight 64-bit registers, two matrix words each (even word in bits 31:0).
// Component c is x*m[c] + y*m[4+c] + z*m[8+c] + w*m[12+c], summed exactly, shifted
// right by FRAC_BITS with flooring and clamped to the signed 32-bit range; the last
// marker rides along untouched. Reset loads the identity matrix. The block takes one
// vertex per cycle while in_stall is low: stage one holds sixteen 32x32
// multipliers, stages two and three form the adder tree, stage four shifts and
// clamps and doubles as the output register. Each stage advances whenever it is
// empty or the stage after it moves, so a stall on the output fills the bubbles
// first and only then pushes back on the input. Write the matrix only while no
// vertex is in flight; writes to an index past the last register are dropped.
module vertex_matrix_transform #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_we,
  input  wire  [vmt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [vmt_pkg::COEF_W-1:0]            cfg_data,
  // vertex input
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  logic signed [vmt_pkg::WORD_W-1:0] in_x,
  input  wire  logic signed [vmt_pkg::WORD_W-1:0] in_y,
  input  wire  logic signed [vmt_pkg::WORD_W-1:0] in_z,
  input  wire  logic signed [vmt_pkg::WORD_W-1:0] in_w,
  input  wire                                   in_last,
  // transformed output
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [vmt_pkg::WORD_W-1:0]     out_x,
  output logic signed [vmt_pkg::WORD_W-1:0]     out_y,
  output logic signed [vmt_pkg::WORD_W-1:0]     out_z,
  output logic signed [vmt_pkg::WORD_W-1:0]     out_w,
  output logic                                  out_last
);

  logic [vmt_pkg::COEF_W-1:0]        coef  [vmt_pkg::NUM_COEF];
  logic signed [vmt_pkg::WORD_W-1:0] mword [vmt_pkg::NUM_WORDS];
  logic signed [vmt_pkg::WORD_W-1:0] vtx   [vmt_pkg::NUM_COMP];
  logic signed [vmt_pkg::WORD_W-1:0] col   [vmt_pkg::NUM_COMP][vmt_pkg::NUM_COMP];
  logic signed [vmt_pkg::WORD_W-1:0] comp  [vmt_pkg::NUM_COMP];

  logic [vmt_pkg::NUM_STG-1:0] vld;
  logic [vmt_pkg::NUM_STG-1:0] rdy;
  logic [vmt_pkg::NUM_STG-1:0] last_pipe;
  vmt_pkg::vmt_adv_t           adv;

  // Matrix registers; drop writes past the last index.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= vmt_pkg::COEF_RESET;
    end else if (cfg_we && (cfg_index < vmt_pkg::NUM_COEF_IDX)) begin
      coef[cfg_index[$clog2(vmt_pkg::NUM_COEF)-1:0]] <= cfg_data;
    end
  end

  // Split registers into words: word k lives in register k/2, half k%2.
  for (genvar k = 0; k < vmt_pkg::NUM_WORDS; k++) begin : g_word
    localparam int RI = k / 2;
    localparam int LO = (k % 2) * vmt_pkg::WORD_W;
    assign mword[k] = coef[RI][LO +: vmt_pkg::WORD_W];
  end

  // Column c of the product takes m[c], m[4+c], m[8+c], m[12+c].
  for (genvar c = 0; c < vmt_pkg::NUM_COMP; c++) begin : g_col
    for (genvar r = 0; r < vmt_pkg::NUM_COMP; r++) begin : g_row
      assign col[c][r] = mword[vmt_pkg::NUM_COMP * r + c];
    end
  end

  assign vtx[0] = in_x;
  assign vtx[1] = in_y;
  assign vtx[2] = in_z;
  assign vtx[3] = in_w;

  // Ready ripples back from the output: a stage loads when empty or when its
  // successor moves.
  assign rdy[3] = !vld[3] || !out_stall;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];

  assign in_stall = !rdy[0];

  // Advance valid bits with the data; hold a stage whose successor is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int s = 1; s < vmt_pkg::NUM_STG; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // Carry the last marker alongside.
  always_ff @(posedge clk) begin
    if (rdy[0]) last_pipe[0] <= in_last;
    for (int s = 1; s < vmt_pkg::NUM_STG; s++) begin
      if (rdy[s]) last_pipe[s] <= last_pipe[s-1];
    end
  end

  for (genvar c = 0; c < vmt_pkg::NUM_COMP; c++) begin : g_dot
    vmt_dot4 #(
      .FRAC_BITS (FRAC_BITS)
    ) u_dot (
      .clk  (clk),
      .adv  (adv),
      .vtx  (vtx),
      .coef (col[c]),
      .comp (comp[c])
    );
  end

  assign out_valid = vld[3];
  assign out_last  = last_pipe[3];
  assign out_x     = comp[0];
  assign out_y     = comp[1];
  assign out_z     = comp[2];
  assign out_w     = comp[3];

  // Back-pressure on the input only when every stage holds an item.
  `VMT_ASSERT_NOW(a_stall_only_full, in_stall, (&vld), "input stalled with a bubble in the pipe")
  // A free output never pushes back on the input.
  `VMT_ASSERT_NOW(a_free_no_stall, !out_stall, !in_stall, "input stalled while output is free")
  // An accepted item lands in the first stage.
  `VMT_ASSERT_NEXT(a_accept_lands, (in_valid && !in_stall), vld[0], "accepted item lost at entry")

endmodule

`default_nettype wire
